FILE: rtl/core/sorted_key_table_macros.svh
// Assertion macros for the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every edge outside reset.
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SKT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SKT_ASSERT(label, prop, msg)
`define SKT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/core/skt_pkg.sv
// Shared constants and types for the sorted key table.
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_REMOVE = 2'd2,
    FN_READ   = 2'd3
  } skt_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } skt_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_PUT,
    S_DONE
  } skt_state_t;

endpackage

FILE: rtl/core/skt_if.sv
// Request and result channel interfaces of the sorted key table.
interface skt_in_if;
  import skt_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  position;

  modport source (output valid, output func, output key, output position, input ready);
  modport sink   (input valid, input func, input key, input position, output ready);
endinterface

interface skt_out_if;
  import skt_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  found_index;
  logic [KEY_W-1:0]  read_key;
  logic [CNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_index, output read_key,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_index, input read_key,
                  input entry_count, output ready);
endinterface

FILE: rtl/core/sorted_key_table.sv
// Sorted key table: key RAM with one read and one write port, walked by a small sequencer, one entry per cycle.
// Search and remove walk up from entry 0; insert makes a downward shift pass, then writes the key
// (into an empty table it writes the key at once). Insert into a full table, search or remove on
// an empty one and read out of range skip the RAM and go straight to the result.
// One item in flight; the RAM read port (registered data) paces the walk at one entry a cycle.
// Next beat is taken in the cycle after the result is loaded into the output register.
// rst_n (sync, active low) clears the count, sequencer and output valid; RAM is not cleared.
module sorted_key_table (
  input logic  clk,
  input logic  rst_n,
  skt_in_if.sink    in_chan,
  skt_out_if.source out_chan
);
  import skt_pkg::*;

  `include "sorted_key_table_macros.svh"

  skt_state_t  state_r, state_nxt;
  skt_func_t   func_r, func_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] put_idx_r, put_idx_nxt;
  skt_status_t      status_r, status_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [KEY_W-1:0] rkey_r, rkey_nxt;

  logic             out_valid_r;
  skt_status_t      out_status_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [KEY_W-1:0] out_key_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_load;

  // key RAM
  logic [KEY_W-1:0] mem [CAPACITY];
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [KEY_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic             in_ready;
  logic             is_last;
  logic [IDX_W-1:0] last_idx;

  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));
  assign is_last  = (CNT_W'(rd_idx_r) + CNT_W'(1)) == cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    hit_nxt     = hit_r;
    put_idx_nxt = put_idx_r;
    status_nxt  = status_r;
    idx_nxt     = idx_r;
    rkey_nxt    = rkey_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data_r;
    out_load    = 1'b0;
    in_ready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          func_nxt   = skt_func_t'(in_chan.func);
          key_nxt    = in_chan.key[KEY_W-1:0];
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          rkey_nxt   = '0;
          state_nxt  = S_DONE;
          unique case (skt_func_t'(in_chan.func)) inside
            FN_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (cnt_r == '0) begin
                put_idx_nxt = '0;
                state_nxt   = S_PUT;
              end else begin
                // walk down from the top entry
                rd_en     = 1'b1;
                rd_addr   = last_idx;
                state_nxt = S_RUN;
              end
            end
            FN_SEARCH, FN_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_RUN;
              end
            end
            FN_READ: begin
              if (CNT_W'(in_chan.position) < cnt_r) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_chan.position);
                state_nxt = S_RUN;
              end else begin
                status_nxt = ST_BEYOND;
              end
            end
          endcase
        end
      end

      S_RUN: begin
        unique case (func_r) inside
          FN_INSERT: begin
            if (rd_data_r >= key_r) begin
              // entry moves up one place
              wr_en   = 1'b1;
              wr_addr = rd_idx_r + IDX_W'(1);
              wr_data = rd_data_r;
              if (rd_idx_r == '0) begin
                put_idx_nxt = '0;
                state_nxt   = S_PUT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = rd_idx_r - IDX_W'(1);
              end
            end else begin
              put_idx_nxt = rd_idx_r + IDX_W'(1);
              state_nxt   = S_PUT;
            end
          end
          FN_SEARCH, FN_REMOVE: begin
            if (hit_r) begin
              // close the gap behind the removed entry
              wr_en   = 1'b1;
              wr_addr = rd_idx_r - IDX_W'(1);
              wr_data = rd_data_r;
              if (is_last) begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = rd_idx_r + IDX_W'(1);
              end
            end else if (rd_data_r == key_r) begin
              hit_nxt = 1'b1;
              idx_nxt = rd_idx_r;
              if (func_r == FN_SEARCH) begin
                state_nxt = S_DONE;
              end else if (is_last) begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = S_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = rd_idx_r + IDX_W'(1);
              end
            end else if (is_last) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = rd_idx_r + IDX_W'(1);
            end
          end
          FN_READ: begin
            rkey_nxt  = rd_data_r;
            state_nxt = S_DONE;
          end
        endcase
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = put_idx_r;
        wr_data   = key_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hit_r   <= hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    key_r     <= key_nxt;
    put_idx_r <= put_idx_nxt;
    status_r  <= status_nxt;
    idx_r     <= idx_nxt;
    rkey_r    <= rkey_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_idx_r    <= idx_r;
      out_key_r    <= rkey_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_index = out_idx_r;
  assign out_chan.read_key    = out_key_r;
  assign out_chan.entry_count = out_cnt_r;

  `SKT_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `SKT_ASSERT(a_cnt_up, cnt_r > $past(cnt_r) |-> cnt_r == $past(cnt_r) + CNT_W'(1), "count jump")
  `SKT_ASSERT(a_cnt_dn, cnt_r < $past(cnt_r) |-> cnt_r == $past(cnt_r) - CNT_W'(1), "count drop")
  `SKT_ASSERT(a_wr_phase, wr_en |-> ((state_r == S_RUN) || (state_r == S_PUT)), "RAM write outside a walk")
  `SKT_ASSERT(a_put_idx, (state_r == S_PUT) |-> (CNT_W'(put_idx_r) <= cnt_r), "insert slot beyond count")
  `SKT_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_chan.valid, "result valid after reset")

endmodule
